// File: src/dnle_pkg.sv
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types and constants for the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

	localparam int LEN_W  = 6;
	localparam int NAME_W = 8;

	localparam logic [7:0] DOT_CHAR  = 8'd46;
	localparam logic [7:0] ZERO_BYTE = 8'd0;

	// One command per input item that gives results.
	typedef struct packed {
		logic       is_label;    // send length byte and buffered characters
		logic [7:0] val;         // byte to send, or label length
		logic       zero_after;  // append the zero terminator after the label
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_CHAR = 3'b010,
		B_ZERO = 3'b100
	} back_state_t;

endpackage

// File: src/dnle_ram.sv
// ----------------------------------------------------------------------------
// dnle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dnle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/dnle_front.sv
// ----------------------------------------------------------------------------
// dnle_front
// Accepts name characters, buffers label characters and issues commands.
// ----------------------------------------------------------------------------
module dnle_front #(
	parameter int LABEL_MAX  = 63,
	parameter int NAME_LIMIT = 255,
	localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         chr,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               push,
	output dnle_pkg::cmd_t     push_cmd,
	input  logic               q_full,
	input  logic               label_done,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic [7:0]         wr_data
);

	logic [dnle_pkg::LEN_W-1:0]  lbl_q, lbl_d, lbl_inc;
	logic [dnle_pkg::NAME_W-1:0] nc_q, nc_d;
	logic                        chunk_q, chunk_d;
	logic                        disc_q, disc_d;
	logic                        busy_q, busy_d;
	logic                        accept;

	assign in_ready = !busy_q && !q_full;
	assign accept   = in_valid && in_ready;
	assign lbl_inc  = lbl_q + dnle_pkg::LEN_W'(1);
	assign wr_addr  = lbl_q[AW-1:0];
	assign wr_data  = chr;

	always_comb begin
		lbl_d    = lbl_q;
		nc_d     = nc_q;
		chunk_d  = chunk_q;
		disc_d   = disc_q;
		busy_d   = busy_q;
		push     = 1'b0;
		push_cmd = '0;
		wr_en    = 1'b0;
		if (label_done) begin
			busy_d = 1'b0;
		end
		if (accept) begin
			if (chr == dnle_pkg::ZERO_BYTE) begin
				if (!disc_q) begin
					push = 1'b1;
					if (lbl_q != '0) begin
						push_cmd.is_label   = 1'b1;
						push_cmd.val        = 8'(lbl_q);
						push_cmd.zero_after = 1'b1;
						busy_d              = 1'b1;
					end else begin
						push_cmd.val = dnle_pkg::ZERO_BYTE;
					end
				end
				lbl_d   = '0;
				nc_d    = '0;
				chunk_d = 1'b0;
				disc_d  = 1'b0;
			end else if (disc_q || nc_q >= dnle_pkg::NAME_W'(NAME_LIMIT - 1)) begin
				// drop
			end else begin
				nc_d = nc_q + dnle_pkg::NAME_W'(1);
				if (chr == dnle_pkg::DOT_CHAR) begin
					if (chunk_q) begin
						chunk_d = 1'b0;
					end else if (lbl_q == '0) begin
						push         = 1'b1;
						push_cmd.val = dnle_pkg::ZERO_BYTE;
						disc_d       = 1'b1;
					end else begin
						push            = 1'b1;
						push_cmd.is_label = 1'b1;
						push_cmd.val    = 8'(lbl_q);
						busy_d          = 1'b1;
						lbl_d           = '0;
					end
				end else begin
					chunk_d = 1'b0;
					wr_en   = 1'b1;
					if (lbl_inc == dnle_pkg::LEN_W'(LABEL_MAX)) begin
						push              = 1'b1;
						push_cmd.is_label = 1'b1;
						push_cmd.val      = 8'(lbl_inc);
						busy_d            = 1'b1;
						chunk_d           = 1'b1;
						lbl_d             = '0;
					end else begin
						lbl_d = lbl_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lbl_q   <= '0;
			nc_q    <= '0;
			chunk_q <= 1'b0;
			disc_q  <= 1'b0;
			busy_q  <= 1'b0;
		end else begin
			lbl_q   <= lbl_d;
			nc_q    <= nc_d;
			chunk_q <= chunk_d;
			disc_q  <= disc_d;
			busy_q  <= busy_d;
		end
	end

endmodule

// File: src/dnle_queue.sv
// ----------------------------------------------------------------------------
// dnle_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module dnle_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dnle_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output dnle_pkg::cmd_t head
);

	dnle_pkg::cmd_t ent_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	logic           do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

// File: src/dnle_back.sv
// ----------------------------------------------------------------------------
// dnle_back
// Carries out commands: sends length, label characters and terminators.
// ----------------------------------------------------------------------------
module dnle_back #(
	parameter int LABEL_MAX = 63,
	localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	input  dnle_pkg::cmd_t q_head,
	output logic           q_pop,
	output logic           rd_en,
	output logic [AW-1:0]  rd_addr,
	input  logic [7:0]     rd_data,
	output logic           label_done,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           run_last
);

	dnle_pkg::back_state_t       st_q, st_d;
	logic [dnle_pkg::LEN_W-1:0]  idx_q, idx_d, cnt_q, cnt_d, idx_inc;
	logic                        zero_q, zero_d;
	logic                        ov_q, ov_d;
	logic [7:0]                  ob_q, ob_d;
	logic                        ol_q, ol_d;
	logic                        out_free, at_end;

	assign out_free = !ov_q || out_ready;
	assign idx_inc  = idx_q + dnle_pkg::LEN_W'(1);
	assign at_end   = (idx_inc == cnt_q);

	always_comb begin
		st_d       = st_q;
		idx_d      = idx_q;
		cnt_d      = cnt_q;
		zero_d     = zero_q;
		ov_d       = ov_q && !out_ready;
		ob_d       = ob_q;
		ol_d       = ol_q;
		q_pop      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = idx_inc[AW-1:0];
		label_done = 1'b0;
		case (st_q)
			dnle_pkg::B_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop = 1'b1;
					ov_d  = 1'b1;
					ob_d  = q_head.val;
					if (q_head.is_label) begin
						ol_d    = 1'b0;
						cnt_d   = q_head.val[dnle_pkg::LEN_W-1:0];
						zero_d  = q_head.zero_after;
						idx_d   = '0;
						rd_en   = 1'b1;
						rd_addr = '0;
						st_d    = dnle_pkg::B_CHAR;
					end else begin
						ol_d = 1'b1;
					end
				end
			end
			dnle_pkg::B_CHAR: begin
				if (out_free) begin
					ov_d = 1'b1;
					ob_d = rd_data;
					ol_d = at_end && !zero_q;
					if (at_end) begin
						if (zero_q) begin
							st_d = dnle_pkg::B_ZERO;
						end else begin
							label_done = 1'b1;
							st_d       = dnle_pkg::B_IDLE;
						end
					end else begin
						rd_en = 1'b1;
						idx_d = idx_inc;
					end
				end
			end
			dnle_pkg::B_ZERO: begin
				if (out_free) begin
					ov_d       = 1'b1;
					ob_d       = dnle_pkg::ZERO_BYTE;
					ol_d       = 1'b1;
					label_done = 1'b1;
					st_d       = dnle_pkg::B_IDLE;
				end
			end
			default: begin
				st_d = dnle_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		cnt_q  <= cnt_d;
		zero_q <= zero_d;
		ob_q   <= ob_d;
		ol_q   <= ol_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= dnle_pkg::B_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;
	assign out_byte  = ob_q;
	assign run_last  = ol_q;

endmodule

// File: src/dns_name_label_encoder.sv
// ----------------------------------------------------------------------------
// dns_name_label_encoder
// Streams a dotted host name into DNS wire labels.
// ----------------------------------------------------------------------------
// channel  handshake              payload
// in       in_valid / in_ready    chr
// out      out_valid / out_ready  out_byte, run_last
//
// The back sends a finished label as its length byte and its characters (with
// a terminator after them if the name ends there), paced by one read of the
// label RAM per sent character; the front holds input while that label is
// read out. A lone terminator goes out as a single beat.
// Reset clears all control state; no clearing pass is needed.
// The front and back stall independently through a two-entry command queue.
// ----------------------------------------------------------------------------
module dns_name_label_encoder #(
	parameter int LABEL_MAX  = 63,
	parameter int NAME_LIMIT = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] chr,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);

	localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

	dnle_pkg::cmd_t push_cmd, q_head;
	logic           push, q_full, q_empty, q_pop, label_done;
	logic           wr_en, rd_en;
	logic [AW-1:0]  wr_addr, rd_addr;
	logic [7:0]     wr_data, rd_data;

	dnle_front #(
		.LABEL_MAX  (LABEL_MAX),
		.NAME_LIMIT (NAME_LIMIT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.chr        (chr),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_full     (q_full),
		.label_done (label_done),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	dnle_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	dnle_ram #(
		.WIDTH (8),
		.DEPTH (LABEL_MAX)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	dnle_back #(
		.LABEL_MAX (LABEL_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.label_done (label_done),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last)
	);

endmodule

// File: src/dnle_checker.sv
// ----------------------------------------------------------------------------
// dnle_checker
// Port-level checks for the DNS name label encoder.
// ----------------------------------------------------------------------------
module dnle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] chr,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last
);

	// hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("output beat changed while stalled");

	a_zero_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte == dnle_pkg::ZERO_BYTE |-> run_last)
		else $error("terminator beat not marked last");

	// hold a stalled input beat
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(chr))
		else $error("input beat changed while stalled");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("output valid right after reset");

endmodule

bind dns_name_label_encoder dnle_checker u_chk (.*);
